// File: rtl/core/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sparse integer set.
// ----------------------------------------------------------------------------
package ssi_pkg;

    // Default number of values the storage can hold.
    localparam int unsigned MAX_VALUES_DEF = 1024;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned VALUE_W = 10;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned SIZE_W  = 11;

    // Reset value of the active size register.
    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_TEST   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic               error;
        logic [COUNT_W-1:0] member_count;
        logic [VALUE_W-1:0] member;
        logic               present;
    } ssi_result_t;

endpackage

// File: rtl/core/ssi_ram.sv
// ----------------------------------------------------------------------------
// ssi_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module ssi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/ssi_engine.sv
// ----------------------------------------------------------------------------
// ssi_engine
// Sequencer around the membership bitmap and the dense member list: reset
// sweep, read-modify-write for insert, and the list walk for clear.
// ----------------------------------------------------------------------------
module ssi_engine #(
    parameter int unsigned MAX_VALUES = ssi_pkg::MAX_VALUES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ssi_pkg::SIZE_W-1:0]   active_size,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ssi_pkg::op_t                 in_op,
    input  logic [ssi_pkg::VALUE_W-1:0]  in_value,
    input  logic [ssi_pkg::POS_W-1:0]    in_position,
    output logic                         res_valid,
    input  logic                         res_ready,
    output ssi_pkg::ssi_result_t         res
);

    import ssi_pkg::*;

    localparam int unsigned AW      = $clog2(MAX_VALUES);
    localparam int unsigned CW      = $clog2(MAX_VALUES + 1);
    localparam int unsigned CAP_INT = (MAX_VALUES > 2047) ? 2047 : MAX_VALUES;
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP_INT);
    localparam logic [CW-1:0] FULL     = CW'(MAX_VALUES);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_VALUES - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      walk_reg, walk_next;
    logic               pend_reg, pend_next;

    logic               bm_we, bm_wdata, bm_re, bm_rdata;
    logic [AW-1:0]      bm_waddr, bm_raddr;
    logic               ls_we, ls_re;
    logic [AW-1:0]      ls_waddr, ls_raddr;
    logic [VALUE_W-1:0] ls_wdata, ls_rdata;

    logic [SIZE_W-1:0]  eff_size;
    logic               in_range;
    logic               pos_bad;
    logic               do_append;
    logic [CW-1:0]      count_after;

    ssi_ram #(.WIDTH(1), .DEPTH(MAX_VALUES)) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    ssi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_VALUES)) u_list (
        .clk   (clk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (ls_wdata),
        .re    (ls_re),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    assign eff_size = (active_size > SIZE_CAP) ? SIZE_CAP : active_size;
    assign in_range = SIZE_W'(value_reg) < eff_size;
    assign pos_bad  = 32'(pos_reg) >= 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            count_reg <= '0;
            walk_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        walk_next   = walk_reg;
        pend_next   = pend_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        bm_we       = 1'b0;
        bm_waddr    = '0;
        bm_wdata    = 1'b0;
        bm_re       = 1'b0;
        bm_raddr    = '0;
        ls_we       = 1'b0;
        ls_waddr    = '0;
        ls_wdata    = '0;
        ls_re       = 1'b0;
        ls_raddr    = '0;
        do_append   = 1'b0;
        count_after = count_reg;

        unique case (state_reg)
            ST_INIT:
            begin
                // Zero the bitmap one entry per cycle after reset.
                bm_we    = 1'b1;
                bm_waddr = AW'(walk_reg);
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_IDX)
                begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    value_next = in_value;
                    pos_next   = in_position;
                    bm_re      = 1'b1;
                    bm_raddr   = AW'(in_value);
                    ls_re      = 1'b1;
                    ls_raddr   = AW'(in_position);
                    if (in_op == OP_CLEAR)
                    begin
                        walk_next  = '0;
                        pend_next  = 1'b0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_CLEAR:
            begin
                // List entry read last cycle names a bit to reset now.
                if (pend_reg)
                begin
                    bm_we    = 1'b1;
                    bm_waddr = AW'(ls_rdata);
                end
                if (walk_reg < count_reg)
                begin
                    ls_re     = 1'b1;
                    ls_raddr  = AW'(walk_reg);
                    walk_next = walk_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                res_valid = 1'b1;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!in_range)
                        begin
                            res.error = 1'b1;
                        end
                        else if (bm_rdata)
                        begin
                            res.present = 1'b1;
                        end
                        else if (count_reg != FULL)
                        begin
                            do_append   = 1'b1;
                            count_after = count_reg + 1'b1;
                        end
                    end
                    OP_TEST:
                    begin
                        if (!in_range)
                        begin
                            res.error = 1'b1;
                        end
                        else
                        begin
                            res.present = bm_rdata;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_after = '0;
                    end
                    default:
                    begin
                        if (pos_bad)
                        begin
                            res.error = 1'b1;
                        end
                        else
                        begin
                            res.member = ls_rdata;
                        end
                    end
                endcase
                res.member_count = COUNT_W'(count_after);
                if (res_ready)
                begin
                    // Commit the writes together with the result.
                    bm_we      = do_append;
                    bm_waddr   = AW'(value_reg);
                    bm_wdata   = 1'b1;
                    ls_we      = do_append;
                    ls_waddr   = AW'(count_reg);
                    ls_wdata   = value_reg;
                    count_next = count_after;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("member count above capacity");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC || !res_ready) |=> $stable(count_reg))
        else $error("member count changed outside a committed result");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == OP_CLEAR && res_ready) |=> count_reg == '0)
        else $error("clear left members behind");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> walk_reg <= count_reg)
        else $error("clear walk ran past the member count");

endmodule

// File: rtl/core/sparse_integer_set.sv
// ----------------------------------------------------------------------------
// sparse_integer_set
// Set of small integers kept as a membership bitmap plus a dense member list.
// ----------------------------------------------------------------------------
// Each request carries an operation in s_tuser: insert, test, clear or read
// the member at a list position. Every request gives exactly one result with
// the member count after the operation and an error flag for a value at or
// above the active size or a position at or beyond the count. Both tables sit
// in synchronous RAMs with a registered read, so insert, test and read pass
// through the idle state (accept and RAM read), then the execute state (check
// and write back), which holds until the result is taken. A clear walks the
// member list one entry per cycle before its result. After reset the block
// zeroes the bitmap, one entry per cycle, before it accepts the first
// request; configuration writes are taken at any time. The result sits in an
// output register, so a new request may be accepted while the previous result
// waits on m_tready. The active size may be changed only while no request is
// in progress; it never alters the stored set.
// ----------------------------------------------------------------------------
module sparse_integer_set #(
    parameter int unsigned MAX_VALUES = ssi_pkg::MAX_VALUES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel: active size.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value [9:0], position [19:10], zero pad
    input  logic [1:0]  s_tuser,   // operation [1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // present [0], member [10:1],
                                   // member_count [21:11], error [22], zero pad
);

    import ssi_pkg::*;

    logic [SIZE_W-1:0] active_size_reg, active_size_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;

    logic              res_valid;
    logic              res_ready;
    ssi_result_t       res;

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;

    assign active_size_next = (cfg_valid && cfg_ready) ? cfg_data : active_size_reg;

    // The engine may hand over a result whenever the output register is
    // empty or being emptied in this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    ssi_engine #(.MAX_VALUES(MAX_VALUES)) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .active_size (active_size_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (op_t'(s_tuser)),
        .in_value    (s_tdata[9:0]),
        .in_position (s_tdata[19:10]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, res.error, res.member_count, res.member, res.present};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RST;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            active_size_reg <= active_size_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/sv/sparse_integer_set_tb.sv
// ----------------------------------------------------------------------------
// sparse_integer_set_tb
// Self-checking testbench for the sparse integer set.
// ----------------------------------------------------------------------------
// A behavioral copy of the set (bitmap, insertion-order list and count) runs
// beside the block. Each accepted request updates it and queues the result
// that the block must return. A checker pops that queue on every accepted
// result and compares all four fields. Directed tests cover the empty set,
// the list boundaries, the active size extremes and a size shrunk below
// existing members. Random phases then sweep several active sizes,
// including zero and values above the storage size. Both streams idle
// at random, and one test holds the result side off long enough to stall
// the request side.
// ----------------------------------------------------------------------------
module sparse_integer_set_tb;

    import ssi_pkg::*;

    localparam int unsigned SET_CAPACITY = MAX_VALUES_DEF;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // value [9:0], position [19:10], zero pad
    logic [1:0]  s_tuser;   // operation [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // present [0], member [10:1],
                            // member_count [21:11], error [22], zero pad

    // Behavioral copy of the set and of the size register.
    logic                member_bit [SET_CAPACITY];
    logic [VALUE_W-1:0]  member_order [SET_CAPACITY];
    int unsigned         member_total;
    logic [SIZE_W-1:0]   size_setting;

    ssi_result_t         expected_results [$];
    int unsigned         failures;
    int unsigned         cycle_count;
    int unsigned         ready_hold;   // cycles the result side still holds off
    bit                  steady;       // suppresses random idling on both sides

    sparse_integer_set dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on demand.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold != 0)
            begin
                ready_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    // Result checker: every accepted result must match the oldest expectation.
    always @(posedge clk)
    begin
        ssi_result_t got;
        ssi_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = ssi_result_t'(m_tdata[22:0]);
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.present !== want.present)
                begin
                    $error("present: expected %0d, actual %0d", want.present, got.present);
                    failures++;
                end
                if (got.member !== want.member)
                begin
                    $error("member: expected %0d, actual %0d", want.member, got.member);
                    failures++;
                end
                if (got.member_count !== want.member_count)
                begin
                    $error("member_count: expected %0d, actual %0d",
                           want.member_count, got.member_count);
                    failures++;
                end
                if (got.error !== want.error)
                begin
                    $error("error: expected %0d, actual %0d", want.error, got.error);
                    failures++;
                end
            end
        end
    end

    // Sizes above the storage act as the storage size.
    function automatic int unsigned usable_size();
        return (size_setting > SET_CAPACITY) ? SET_CAPACITY : size_setting;
    endfunction

    // Applies one request to the behavioral set and returns its result.
    function automatic ssi_result_t apply_set_operation(op_t op, logic [VALUE_W-1:0] value,
                                                        logic [POS_W-1:0] pos);
        ssi_result_t outcome = '0;
        int unsigned limit = usable_size();
        case (op)
            OP_INSERT:
                if (value >= limit)
                    outcome.error = 1'b1;
                else if (member_bit[value])
                    outcome.present = 1'b1;
                else if (member_total < SET_CAPACITY)
                begin
                    member_bit[value] = 1'b1;
                    member_order[member_total] = value;
                    member_total++;
                end
            OP_TEST:
                if (value >= limit)
                    outcome.error = 1'b1;
                else
                    outcome.present = member_bit[value];
            OP_CLEAR:
            begin
                for (int unsigned k = 0; k < member_total; k++)
                    member_bit[member_order[k]] = 1'b0;
                member_total = 0;
            end
            default:
                if (pos >= member_total)
                    outcome.error = 1'b1;
                else
                    outcome.member = member_order[pos];
        endcase
        outcome.member_count = COUNT_W'(member_total);
        return outcome;
    endfunction

    // Offers one request, waits for the handshake and queues its result.
    task automatic send_request(op_t op, logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
        if (!steady && $urandom_range(0, 99) < 9)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pos, value};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(apply_set_operation(op, value, pos));
    endtask

    // Stops offering requests and waits for every outstanding result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_active_size(logic [SIZE_W-1:0] size);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_setting = size;
    endtask

    // Random traffic: mostly inserts so the set grows, tests that often aim
    // at real members, and reads inside the list and just past its end.
    task automatic random_requests(int unsigned n, int unsigned clear_pct);
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        int unsigned        pick;
        int unsigned        limit;
        repeat (n)
        begin
            limit = usable_size();
            pick  = $urandom_range(0, 99);
            if (pick < clear_pct)
                op = OP_CLEAR;
            else if (pick < clear_pct + 45)
                op = OP_INSERT;
            else if (pick < clear_pct + 70)
                op = OP_TEST;
            else
                op = OP_READ;

            value = VALUE_W'($urandom_range(0, 1023));
            if (limit != 0 && $urandom_range(0, 9) != 0)
                value = VALUE_W'($urandom_range(0, limit - 1));
            if (op == OP_TEST && member_total != 0 && $urandom_range(0, 1) == 1)
                value = member_order[$urandom_range(0, member_total - 1)];

            pos = POS_W'($urandom_range(0, 1023));
            if (op == OP_READ)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    pos = POS_W'(member_total);
                else if (pick > 1 && member_total != 0)
                    pos = POS_W'($urandom_range(0, member_total - 1));
            end
            send_request(op, value, pos);
        end
    endtask

    task automatic test_empty_set();
        send_request(OP_READ, 10'd0, 10'd0);
        send_request(OP_TEST, 10'd0, 10'd0);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        send_request(OP_TEST, 10'd1023, 10'd1023);
    endtask

    task automatic test_insert_and_read();
        send_request(OP_INSERT, 10'd0, 10'd0);
        send_request(OP_INSERT, 10'd1023, 10'd0);
        send_request(OP_INSERT, 10'd0, 10'd1023);
        send_request(OP_TEST, 10'd1023, 10'd0);
        send_request(OP_TEST, 10'd512, 10'd0);
        send_request(OP_READ, 10'd0, 10'd0);
        send_request(OP_READ, 10'd0, 10'd1);
        // Position equal to the count is just past the end.
        send_request(OP_READ, 10'd0, 10'd2);
        send_request(OP_READ, 10'd1023, 10'd1023);
    endtask

    task automatic test_size_extremes();
        write_active_size(11'd1);
        send_request(OP_INSERT, 10'd0, 10'd0);
        send_request(OP_INSERT, 10'd1, 10'd0);
        send_request(OP_TEST, 10'd1023, 10'd0);
        // Reads ignore the size, so the member above it is still visible.
        send_request(OP_READ, 10'd0, 10'd1);
        write_active_size(11'd0);
        send_request(OP_INSERT, 10'd0, 10'd0);
        send_request(OP_TEST, 10'd0, 10'd0);
        write_active_size(11'd2047);
        send_request(OP_INSERT, 10'd1022, 10'd0);
        send_request(OP_TEST, 10'd1023, 10'd0);
        write_active_size(11'd1024);
        send_request(OP_CLEAR, 10'd1023, 10'd1023);
        send_request(OP_READ, 10'd0, 10'd0);
        send_request(OP_TEST, 10'd1023, 10'd0);
        send_request(OP_TEST, 10'd0, 10'd0);
    endtask

    // Members above a reduced size stay in the list, report errors on test
    // and insert, and are still removed by a clear.
    task automatic test_size_shrink();
        logic [VALUE_W-1:0] high_values [24];
        write_active_size(11'd1024);
        send_request(OP_CLEAR, 10'd0, 10'd0);
        foreach (high_values[i])
        begin
            high_values[i] = VALUE_W'($urandom_range(64, 1023));
            send_request(OP_INSERT, high_values[i], POS_W'($urandom_range(0, 1023)));
            if (i % 3 == 0)
                send_request(OP_INSERT, VALUE_W'($urandom_range(0, 63)),
                             POS_W'($urandom_range(0, 1023)));
        end
        write_active_size(11'd64);
        foreach (high_values[i])
        begin
            if (i % 2 == 0)
                send_request(OP_TEST, high_values[i], 10'd0);
            else
                send_request(OP_INSERT, high_values[i], 10'd0);
        end
        for (int unsigned p = 0; p < member_total; p += 3)
            send_request(OP_READ, 10'd0, POS_W'(p));
        send_request(OP_CLEAR, 10'd0, 10'd0);
        write_active_size(11'd1024);
        foreach (high_values[i])
            if (i % 4 == 0)
                send_request(OP_TEST, high_values[i], 10'd0);
    endtask

    // The result side stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        ready_hold = 300;
        random_requests(40, 2);
    endtask

    task automatic test_random_sizes();
        int unsigned sizes [10];
        sizes = '{1024, 2047, 1, 0, 2, 37, 1025, 0, 300, 1024};
        sizes[7] = $urandom_range(3, 1023);
        foreach (sizes[i])
        begin
            write_active_size(SIZE_W'(sizes[i]));
            steady = (i == 5);
            if (sizes[i] >= SET_CAPACITY)
                random_requests(150, 1);
            else
                random_requests(100, 4);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        failures     = 0;
        cycle_count  = 0;
        ready_hold   = 0;
        steady       = 1'b0;
        member_total = 0;
        size_setting = ACTIVE_SIZE_RST;
        foreach (member_bit[i])
        begin
            member_bit[i]   = 1'b0;
            member_order[i] = '0;
        end
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_INSERT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_set();
        test_insert_and_read();
        test_size_extremes();
        test_size_shrink();
        test_backpressure();
        test_random_sizes();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sparse_integer_set.f
rtl/core/ssi_pkg.sv
rtl/core/ssi_ram.sv
rtl/core/ssi_engine.sv
rtl/core/sparse_integer_set.sv
tb/sv/sparse_integer_set_tb.sv
